@@ rtl/dns_query_header_parser_macros.svh @@
// assertion macros shared by the checker
`ifndef DNS_QUERY_HEADER_PARSER_MACROS_SVH
`define DNS_QUERY_HEADER_PARSER_MACROS_SVH

// same-cycle implication, disabled in reset
`define DNSQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DNSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dnsq_pkg.sv @@
`default_nettype none
package dnsq_pkg;

  // parse phases
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_CHARS  = 3'd2,
    PH_QUEST  = 3'd3,
    PH_SKIP   = 3'd4
  } phase_t;

  localparam int unsigned HDR_WORDS    = 6;
  localparam int unsigned QST_WORDS    = 2;
  localparam logic [3:0]  HDR_LAST_IDX = 4'd11;
  localparam logic [3:0]  QST_LAST_IDX = 4'd3;
  localparam logic [7:0]  DOT_CHAR     = 8'h2E;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_TRUNC = 1'b1;

  // big-endian byte placement: even position is the high byte
  function automatic logic [15:0] put_byte(input logic [15:0] word,
                                           input logic        odd_pos,
                                           input logic [7:0]  b);
    logic [15:0] res;
    if (odd_pos) begin
      res = {word[15:8], b};
    end else begin
      res = {b, word[7:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/dnsq_in_if.sv @@
`default_nettype none
interface dnsq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source (output valid, output packet_byte, output last_byte, input ready);
  modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface
`default_nettype wire

@@ rtl/dnsq_out_if.sv @@
`default_nettype none
interface dnsq_out_if;
  logic        valid;
  logic        ready;
  logic        char_valid;
  logic [7:0]  name_char;
  logic        done_valid;
  logic        status;
  logic [15:0] query_id;
  logic [15:0] flag_word;
  logic [15:0] question_count;
  logic [15:0] answer_count;
  logic [15:0] authority_count;
  logic [15:0] additional_count;
  logic [15:0] query_type;
  logic [15:0] query_class;

  modport source (
    output valid, input ready,
    output char_valid, output name_char, output done_valid, output status,
    output query_id, output flag_word, output question_count, output answer_count,
    output authority_count, output additional_count,
    output query_type, output query_class
  );
  modport sink (
    input valid, output ready,
    input char_valid, input name_char, input done_valid, input status,
    input query_id, input flag_word, input question_count, input answer_count,
    input authority_count, input additional_count,
    input query_type, input query_class
  );
endinterface
`default_nettype wire

@@ rtl/dns_query_header_parser.sv @@
// channel   dir  handshake      payload
// in_chan   in   valid/ready    packet_byte[7:0], last_byte
// out_chan  out  valid/ready    char_valid, name_char, done_valid, status, 8 words
//
// one item per cycle sustained while no waiting result is stalled; a result appears in the cycle after its item
// the parse state updates in the accepting cycle, the result sits in an output register
// in_chan.ready drops only while a result waits and out_chan.ready is low
// rst_n is synchronous, active low; it clears parse state and the output valid
// the byte flagged last always returns the parse state to its post-reset values
`default_nettype none
module dns_query_header_parser
  import dnsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  dnsq_in_if.sink    in_chan,
  dnsq_out_if.source out_chan
);

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        first_r, first_nxt;
  logic [15:0] hdr_r [HDR_WORDS];
  logic [15:0] hdr_nxt [HDR_WORDS];
  logic [15:0] qst_r [QST_WORDS];
  logic [15:0] qst_nxt [QST_WORDS];

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        cv_r, dv_r, status_r;
  logic [7:0]  ch_r;
  logic [15:0] hdr_out_r [HDR_WORDS];
  logic [15:0] qst_out_r [QST_WORDS];

  logic       accept;
  logic       cv, dv, ok;
  logic [7:0] ch;
  logic       load;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    left_nxt  = left_r;
    first_nxt = first_r;
    hdr_nxt   = hdr_r;
    qst_nxt   = qst_r;
    cv        = 1'b0;
    ch        = 8'h00;
    ok        = 1'b0;
    dv        = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        for (int k = 0; k < HDR_WORDS; k++) begin
          if (idx_r[3:1] == 3'(k)) begin
            hdr_nxt[k] = put_byte(hdr_r[k], idx_r[0], in_chan.packet_byte);
          end
        end
        if (idx_r >= HDR_LAST_IDX) begin
          idx_nxt   = 4'd0;
          phase_nxt = PH_LEN;
          first_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      PH_LEN: begin
        if (in_chan.packet_byte == 8'h00) begin
          // zero length closes the name
          phase_nxt = PH_QUEST;
          idx_nxt   = 4'd0;
        end else begin
          if (!first_r) begin
            cv = 1'b1;
            ch = DOT_CHAR;
          end
          first_nxt = 1'b0;
          left_nxt  = in_chan.packet_byte;
          phase_nxt = PH_CHARS;
        end
      end
      PH_CHARS: begin
        cv       = 1'b1;
        ch       = in_chan.packet_byte;
        left_nxt = left_r - 8'd1;
        if (left_nxt == 8'd0) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_QUEST: begin
        qst_nxt[idx_r[1]] = put_byte(qst_r[idx_r[1]], idx_r[0], in_chan.packet_byte);
        if (idx_r >= QST_LAST_IDX) begin
          dv        = 1'b1;
          ok        = 1'b1;
          phase_nxt = PH_SKIP;
          idx_nxt   = 4'd0;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      default: begin
        // trailing bytes after the question
      end
    endcase

    // early end of packet reports what has been captured
    if (in_chan.last_byte && !ok && phase_nxt != PH_SKIP) begin
      dv = 1'b1;
    end

    load = accept && (cv || dv);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // parse state registers, back to reset values after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_chan.last_byte)) begin
      phase_r <= PH_HEADER;
      idx_r   <= 4'd0;
      left_r  <= 8'd0;
      first_r <= 1'b1;
      for (int k = 0; k < HDR_WORDS; k++) begin
        hdr_r[k] <= 16'h0000;
      end
      for (int k = 0; k < QST_WORDS; k++) begin
        qst_r[k] <= 16'h0000;
      end
    end else if (accept) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      left_r  <= left_nxt;
      first_r <= first_nxt;
      hdr_r   <= hdr_nxt;
      qst_r   <= qst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, unused fields forced to zero
  always_ff @(posedge clk) begin
    if (load) begin
      cv_r     <= cv;
      ch_r     <= cv ? ch : 8'h00;
      dv_r     <= dv;
      status_r <= (dv && !ok) ? STATUS_TRUNC : STATUS_OK;
      for (int k = 0; k < HDR_WORDS; k++) begin
        hdr_out_r[k] <= dv ? hdr_nxt[k] : 16'h0000;
      end
      for (int k = 0; k < QST_WORDS; k++) begin
        qst_out_r[k] <= dv ? qst_nxt[k] : 16'h0000;
      end
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.char_valid       = cv_r;
  assign out_chan.name_char        = ch_r;
  assign out_chan.done_valid       = dv_r;
  assign out_chan.status           = status_r;
  assign out_chan.query_id         = hdr_out_r[0];
  assign out_chan.flag_word        = hdr_out_r[1];
  assign out_chan.question_count   = hdr_out_r[2];
  assign out_chan.answer_count     = hdr_out_r[3];
  assign out_chan.authority_count  = hdr_out_r[4];
  assign out_chan.additional_count = hdr_out_r[5];
  assign out_chan.query_type       = qst_out_r[0];
  assign out_chan.query_class      = qst_out_r[1];

endmodule
`default_nettype wire

@@ rtl/dnsq_checker.sv @@
`default_nettype none
`include "dns_query_header_parser_macros.svh"
module dnsq_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        char_valid,
  input wire logic [7:0]  name_char,
  input wire logic        done_valid,
  input wire logic        status,
  input wire logic [15:0] query_type
);

  // a stalled result holds
  `DNSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(name_char) && $stable(status) && $stable(query_type), "stalled result changed")

  // a new result needs an item taken the cycle before
  `DNSQ_ASSERT_NOW(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready), "result without an accepted item")

  // input is never held off while the output register is free
  `DNSQ_ASSERT_NOW(a_in_free, clk, rst_n, !out_valid || out_ready, in_ready, "input stalled with room downstream")

  // a result carries something, and summary fields are clear without a report
  `DNSQ_ASSERT_NOW(a_out_fields, clk, rst_n, out_valid && !done_valid, char_valid && status == 1'b0 && query_type == 16'h0000, "bad result fields")

endmodule

bind dns_query_header_parser dnsq_port_checker u_dnsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .char_valid (out_chan.char_valid),
  .name_char  (out_chan.name_char),
  .done_valid (out_chan.done_valid),
  .status     (out_chan.status),
  .query_type (out_chan.query_type)
);
`default_nettype wire
